FILE: sv/mts_pkg.sv
// Shared codes and controller/datapath interface types for the minute task scheduler.
`timescale 1ns / 1ps

package mts_pkg;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_SET    = 2'd3;

    localparam logic [2:0] KIND_ADD       = 3'd0;
    localparam logic [2:0] KIND_REMOVE    = 3'd1;
    localparam logic [2:0] KIND_SET       = 3'd2;
    localparam logic [2:0] KIND_TICK_NONE = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_AHEAD = 2'd2;

    localparam logic [5:0] SEC_LAST = 6'd59;

    typedef struct packed {
        logic load;
        logic set_time;
        logic tick;
        logic add_take;
        logic add_full;
        logic scan_rd;
        logic scan_remove;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       wrap;
        logic       slot_free;
    } stat_t;

endpackage

FILE: sv/minute_task_scheduler_table.sv
// Top level of the minute task scheduler: timed task table driven by one-second ticks.
//
//  Channel   Handshake        Ports
//  command   start / busy     mode, time_minutes, seconds_in, task_id, task_tag
//  result    strobe           kind, result_id, result_tag, status, last,
//                             current_minutes, current_seconds, ticking
//
// A set time or a tick that does not wrap the minute is done in the exec state; an add walks
// over the slot valid bits to the first free slot.
// A remove or a minute-wrapping tick scans every slot, one slot memory read a cycle.
// Each result is on the ports for one cycle, in the cycle strobe is high; no stall is possible.
// Reset frees every slot at once through the valid bits; there is no clearing pass.
`timescale 1ns / 1ps

module minute_task_scheduler_table #(
    parameter int NUM_SLOTS = 8,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] time_minutes,
    input  logic [5:0]  seconds_in,
    input  logic [15:0] task_id,
    input  logic [15:0] task_tag,
    output logic        strobe,
    output logic [2:0]  kind,
    output logic [15:0] result_id,
    output logic [15:0] result_tag,
    output logic [1:0]  status,
    output logic        last,
    output logic [31:0] current_minutes,
    output logic [5:0]  current_seconds,
    output logic        ticking
);

    localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    mts_pkg::cmd_t       cmd;
    mts_pkg::stat_t      stat;
    logic [IDX_BITS-1:0] idx;

    mts_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_BITS  (IDX_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd),
        .idx   (idx)
    );

    mts_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS),
        .IDX_BITS  (IDX_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .idx             (idx),
        .stat            (stat),
        .mode            (mode),
        .time_minutes    (time_minutes),
        .seconds_in      (seconds_in),
        .task_id         (task_id),
        .task_tag        (task_tag),
        .strobe          (strobe),
        .kind            (kind),
        .result_id       (result_id),
        .result_tag      (result_tag),
        .status          (status),
        .last            (last),
        .current_minutes (current_minutes),
        .current_seconds (current_seconds),
        .ticking         (ticking)
    );

`ifndef SYNTHESIS
    // An accepted transfer always keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // Only fired tasks can be followed by further results of the same command.
    a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind != mts_pkg::KIND_FIRED) |-> last)
        else $error("non-fire result without last");

    // Tasks fire only while the clock runs, and always with ok status.
    a_fire_ticking: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == mts_pkg::KIND_FIRED) |-> ticking && (status == mts_pkg::STATUS_OK))
        else $error("task fired while clock stopped or with bad status");
`endif

endmodule

FILE: sv/mts_ctrl.sv
// Sequencing state machine of the minute task scheduler.
`timescale 1ns / 1ps

module mts_ctrl #(
    parameter int NUM_SLOTS = 8,
    parameter int IDX_BITS  = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mts_pkg::stat_t        stat,
    output mts_pkg::cmd_t         cmd,
    output logic [IDX_BITS-1:0]   idx
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_SLOTS - 1);

    state_t              state_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic                busy_reg;
    logic                at_last;

    assign at_last = (idx_reg == LAST_IDX);
    assign busy    = busy_reg;
    assign idx     = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                        idx_reg   <= '0;
                    end
                end
                S_EXEC:
                begin
                    case (stat.mode)
                        mts_pkg::MODE_SET:
                        begin
                            state_reg <= S_IDLE;
                            busy_reg  <= 1'b0;
                        end
                        mts_pkg::MODE_TICK:
                        begin
                            if (stat.wrap)
                            begin
                                state_reg <= S_SCAN;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                                busy_reg  <= 1'b0;
                            end
                        end
                        mts_pkg::MODE_ADD:
                        begin
                            state_reg <= S_ADD;
                        end
                        default:
                        begin
                            state_reg <= S_SCAN;
                        end
                    endcase
                end
                S_ADD:
                begin
                    if (stat.slot_free || at_last)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (at_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_EXEC:
            begin
                cmd.set_time = (stat.mode == mts_pkg::MODE_SET);
                cmd.tick     = (stat.mode == mts_pkg::MODE_TICK);
            end
            S_ADD:
            begin
                cmd.add_take = stat.slot_free;
                cmd.add_full = !stat.slot_free && at_last;
            end
            S_SCAN:
            begin
                cmd.scan_rd     = 1'b1;
                cmd.scan_remove = (stat.mode == mts_pkg::MODE_REMOVE);
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/mts_datapath.sv
// Slot memory, clock registers and result formatting of the minute task scheduler.
`timescale 1ns / 1ps

module mts_datapath #(
    parameter int NUM_SLOTS = 8,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 32,
    parameter int IDX_BITS  = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mts_pkg::cmd_t       cmd,
    input  logic [IDX_BITS-1:0] idx,
    output mts_pkg::stat_t      stat,
    input  logic [1:0]          mode,
    input  logic [31:0]         time_minutes,
    input  logic [5:0]          seconds_in,
    input  logic [15:0]         task_id,
    input  logic [15:0]         task_tag,
    output logic                strobe,
    output logic [2:0]          kind,
    output logic [15:0]         result_id,
    output logic [15:0]         result_tag,
    output logic [1:0]          status,
    output logic                last,
    output logic [31:0]         current_minutes,
    output logic [5:0]          current_seconds,
    output logic                ticking
);

    // Command registers
    logic [1:0]           mode_reg;
    logic [TIME_BITS-1:0] tmin_reg;
    logic [5:0]           secs_reg;
    logic [ID_BITS-1:0]   tid_reg;
    logic [15:0]          tag_reg;

    // Clock and id state
    logic [TIME_BITS-1:0] clock_min_reg;
    logic [TIME_BITS-1:0] clock_min_next;
    logic [5:0]           clock_sec_reg;
    logic [5:0]           clock_sec_next;
    logic                 run_reg;
    logic                 run_next;
    logic [ID_BITS-1:0]   id_ctr_reg;
    logic [ID_BITS-1:0]   id_inc;
    logic [ID_BITS-1:0]   new_id;
    logic [NUM_SLOTS-1:0] valid_reg;

    // Slot memory and its read stage
    logic [ID_BITS-1:0]   mem_id  [NUM_SLOTS];
    logic [TIME_BITS-1:0] mem_due [NUM_SLOTS];
    logic [15:0]          mem_tag [NUM_SLOTS];
    logic [ID_BITS-1:0]   rd_id_reg;
    logic [TIME_BITS-1:0] rd_due_reg;
    logic [15:0]          rd_tag_reg;
    logic                 s2_valid_reg;
    logic                 s2_remove_reg;
    logic [IDX_BITS-1:0]  s2_idx_reg;
    logic                 s2_hit;

    // Fired task waiting until it is known whether it is the final result
    logic                 pend_reg;
    logic [ID_BITS-1:0]   pend_id_reg;
    logic [15:0]          pend_tag_reg;

    // Result assembly
    logic                 emit;
    logic [2:0]           e_kind;
    logic [ID_BITS-1:0]   e_id;
    logic [15:0]          e_tag;
    logic [1:0]           e_status;
    logic                 e_last;
    logic [63:0]          tmin_wide;
    logic [63:0]          tid_wide;
    logic [63:0]          eid_wide;
    logic [63:0]          cmin_wide;
    logic                 wrap;

    logic                 strobe_reg;
    logic [2:0]           kind_reg;
    logic [15:0]          id_out_reg;
    logic [15:0]          tag_out_reg;
    logic [1:0]           status_reg;
    logic                 last_reg;
    logic [31:0]          cmin_out_reg;
    logic [5:0]           csec_out_reg;
    logic                 ticking_reg;

    assign tmin_wide = 64'(time_minutes);
    assign tid_wide  = 64'(task_id);
    assign eid_wide  = 64'(e_id);
    assign cmin_wide = 64'(clock_min_next);

    assign wrap   = run_reg && (clock_sec_reg >= mts_pkg::SEC_LAST);
    assign id_inc = id_ctr_reg + 1'b1;
    assign new_id = (id_inc == '0) ? ID_BITS'(1) : id_inc;

    assign stat.mode      = mode_reg;
    assign stat.wrap      = wrap;
    assign stat.slot_free = !valid_reg[idx];

    assign s2_hit = s2_valid_reg && valid_reg[s2_idx_reg] &&
                    (s2_remove_reg ? (rd_id_reg == tid_reg) : (clock_min_reg >= rd_due_reg));

    always_comb
    begin
        clock_min_next = clock_min_reg;
        clock_sec_next = clock_sec_reg;
        run_next       = run_reg;
        if (cmd.set_time)
        begin
            if (clock_min_reg < tmin_reg)
            begin
                clock_min_next = tmin_reg;
                clock_sec_next = secs_reg;
                run_next       = 1'b1;
            end
            else if (clock_min_reg == tmin_reg && secs_reg > clock_sec_reg)
            begin
                clock_sec_next = secs_reg;
                run_next       = 1'b1;
            end
            else
            begin
                run_next = 1'b0;
            end
        end
        else if (cmd.tick && run_reg)
        begin
            if (wrap)
            begin
                clock_sec_next = '0;
                clock_min_next = clock_min_reg + 1'b1;
            end
            else
            begin
                clock_sec_next = clock_sec_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        emit     = 1'b0;
        e_kind   = mts_pkg::KIND_TICK_NONE;
        e_id     = '0;
        e_tag    = '0;
        e_status = mts_pkg::STATUS_OK;
        e_last   = 1'b1;
        if (cmd.set_time)
        begin
            emit     = 1'b1;
            e_kind   = mts_pkg::KIND_SET;
            e_status = run_next ? mts_pkg::STATUS_OK : mts_pkg::STATUS_AHEAD;
        end
        else if (cmd.tick)
        begin
            emit = !wrap;
        end
        else if (cmd.add_take)
        begin
            emit   = 1'b1;
            e_kind = mts_pkg::KIND_ADD;
            e_id   = new_id;
        end
        else if (cmd.add_full)
        begin
            emit     = 1'b1;
            e_kind   = mts_pkg::KIND_ADD;
            e_status = mts_pkg::STATUS_FULL;
        end
        else if (cmd.finish)
        begin
            emit = 1'b1;
            if (mode_reg == mts_pkg::MODE_REMOVE)
            begin
                e_kind = mts_pkg::KIND_REMOVE;
            end
            else if (pend_reg)
            begin
                e_kind = mts_pkg::KIND_FIRED;
                e_id   = pend_id_reg;
                e_tag  = pend_tag_reg;
            end
        end
        else if (s2_hit && !s2_remove_reg && pend_reg)
        begin
            emit   = 1'b1;
            e_kind = mts_pkg::KIND_FIRED;
            e_id   = pend_id_reg;
            e_tag  = pend_tag_reg;
            e_last = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_min_reg <= '0;
            clock_sec_reg <= '0;
            run_reg       <= 1'b1;
            id_ctr_reg    <= '0;
            valid_reg     <= '0;
            s2_valid_reg  <= 1'b0;
            s2_remove_reg <= 1'b0;
            pend_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            clock_min_reg <= clock_min_next;
            clock_sec_reg <= clock_sec_next;
            run_reg       <= run_next;
            s2_valid_reg  <= cmd.scan_rd;
            s2_remove_reg <= cmd.scan_remove;
            strobe_reg    <= emit;
            if (cmd.add_take)
            begin
                id_ctr_reg     <= new_id;
                valid_reg[idx] <= 1'b1;
            end
            if (s2_hit)
            begin
                valid_reg[s2_idx_reg] <= 1'b0;
            end
            if (cmd.finish)
            begin
                pend_reg <= 1'b0;
            end
            else if (s2_hit && !s2_remove_reg)
            begin
                pend_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            tmin_reg <= tmin_wide[TIME_BITS-1:0];
            secs_reg <= seconds_in;
            tid_reg  <= tid_wide[ID_BITS-1:0];
            tag_reg  <= task_tag;
        end
        if (cmd.add_take)
        begin
            mem_id[idx]  <= new_id;
            mem_due[idx] <= tmin_reg;
            mem_tag[idx] <= tag_reg;
        end
        if (cmd.scan_rd)
        begin
            rd_id_reg  <= mem_id[idx];
            rd_due_reg <= mem_due[idx];
            rd_tag_reg <= mem_tag[idx];
            s2_idx_reg <= idx;
        end
        if (s2_hit && !s2_remove_reg)
        begin
            pend_id_reg  <= rd_id_reg;
            pend_tag_reg <= rd_tag_reg;
        end
        if (emit)
        begin
            kind_reg     <= e_kind;
            id_out_reg   <= eid_wide[15:0];
            tag_out_reg  <= e_tag;
            status_reg   <= e_status;
            last_reg     <= e_last;
            cmin_out_reg <= cmin_wide[31:0];
            csec_out_reg <= clock_sec_next;
            ticking_reg  <= run_next;
        end
    end

    assign strobe          = strobe_reg;
    assign kind            = kind_reg;
    assign result_id       = id_out_reg;
    assign result_tag      = tag_out_reg;
    assign status          = status_reg;
    assign last            = last_reg;
    assign current_minutes = cmin_out_reg;
    assign current_seconds = csec_out_reg;
    assign ticking         = ticking_reg;

endmodule
